[rtl/ppfb_pkg.sv]
// ----------------------------------------------------------------------------
// Paged pixel frame buffer package
// Shared item types, operation and result codes, and display command bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package ppfb_pkg;

    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 8;

    localparam logic [1:0] OP_SET     = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_FILL    = 2'd2;
    localparam logic [1:0] OP_REFRESH = 2'd3;

    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_CMD   = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;

    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

    typedef struct packed {
        logic [1:0] op;
        logic [6:0] x;
        logic [5:0] y;
        logic [7:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] payload;
        logic        last;
    } t_out_item;

endpackage

`default_nettype wire

[rtl/paged_pixel_framebuffer_top.sv]
// ----------------------------------------------------------------------------
// Paged pixel frame buffer
// Monochrome frame of PAGES by COLUMNS bytes with per-page dirty refresh.
// ----------------------------------------------------------------------------
// The frame lives in one RAM of PAGES*COLUMNS bytes and the block handles one
// item at a time. A pixel set is accepted with its read and then written back;
// a pixel read is accepted with its read, captures the bit, then waits on the
// output. A fill writes one byte per cycle until the whole frame is written;
// after reset the same sweep clears the frame, and no item is accepted until
// it ends. A refresh scans one page flag per cycle until it finds a dirty page
// or has tried every page, then issues the command item and reads the page one
// byte per cycle, pausing after each eight bytes for a drain state and any wait
// on the output before it gives the data item.
`default_nettype none

module paged_pixel_framebuffer_top #(
    parameter int COLUMNS = ppfb_pkg::COLUMNS_DEF,
    parameter int PAGES   = ppfb_pkg::PAGES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire ppfb_pkg::t_in_item  i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output ppfb_pkg::t_out_item      o_out
);

    localparam int FRAME = PAGES * COLUMNS;
    localparam int AW    = $clog2(FRAME);
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int TW    = $clog2(PAGES + 1);
    localparam int WPP   = (COLUMNS + 7) / 8;
    localparam int CCW   = $clog2(WPP * 8 + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FILL  = 4'd1;
    localparam logic [3:0] S_SETW  = 4'd2;
    localparam logic [3:0] S_PXW   = 4'd3;
    localparam logic [3:0] S_PXO   = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_CMD   = 4'd6;
    localparam logic [3:0] S_READ  = 4'd7;
    localparam logic [3:0] S_DRAIN = 4'd8;
    localparam logic [3:0] S_PUT   = 4'd9;

    logic [3:0]          r_state,     n_state;
    logic [AW-1:0]       r_addr,      n_addr;
    logic [7:0]          r_fill,      n_fill;
    logic [7:0]          r_mask,      n_mask;
    logic                r_setv,      n_setv;
    logic [PW-1:0]       r_page,      n_page;
    logic [AW-1:0]       r_page_base, n_page_base;
    logic                r_bit,       n_bit;
    logic [PAGES-1:0]    r_dirty,     n_dirty;
    logic [PW-1:0]       r_ptr,       n_ptr;
    logic [TW-1:0]       r_tries,     n_tries;
    logic [CCW-1:0]      r_col,       n_col;
    logic                r_pend,      n_pend;
    logic [2:0]          r_pend_lane, n_pend_lane;
    logic                r_pend_zero, n_pend_zero;
    logic [63:0]         r_word,      n_word;
    logic                r_out_valid, n_out_valid;
    ppfb_pkg::t_out_item r_out,       n_out;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_rdata;
    logic          w_slot;
    logic          w_load;
    logic [2:0]    w_in_page;
    logic          w_inside;
    logic [AW-1:0] w_pix_addr;
    logic [7:0]    w_pix_mask;
    logic [AW-1:0] w_col_addr;

    ppfb_ram #(
        .WIDTH(8),
        .DEPTH(FRAME)
    ) u_frame_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_slot     = !r_out_valid || !i_out_stall;
    assign w_in_page  = i_in.y[5:3];
    assign w_inside   = (32'(i_in.x) < COLUMNS) && (32'(w_in_page) < PAGES);
    assign w_pix_addr = AW'(32'(w_in_page) * COLUMNS + 32'(i_in.x));
    assign w_pix_mask = 8'd1 << i_in.y[2:0];
    assign w_col_addr = r_page_base + AW'(r_col);

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_fill      = r_fill;
        n_mask      = r_mask;
        n_setv      = r_setv;
        n_page      = r_page;
        n_page_base = r_page_base;
        n_bit       = r_bit;
        n_dirty     = r_dirty;
        n_ptr       = r_ptr;
        n_tries     = r_tries;
        n_col       = r_col;
        n_pend      = 1'b0;
        n_pend_lane = r_pend_lane;
        n_pend_zero = r_pend_zero;
        n_word      = r_word;
        n_out       = r_out;
        w_load      = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_addr;
        w_wdata     = r_fill;
        w_raddr     = r_addr;

        if (r_pend) begin
            n_word[8*r_pend_lane +: 8] = r_pend_zero ? 8'd0 : w_rdata;
        end

        unique case (r_state)
            S_IDLE: begin
                w_raddr = w_pix_addr;
                if (i_in_valid) begin
                    unique case (i_in.op)
                        ppfb_pkg::OP_SET: begin
                            n_addr = w_pix_addr;
                            n_mask = w_pix_mask;
                            n_setv = (i_in.value != 8'd0);
                            n_page = PW'(w_in_page);
                            if (w_inside) begin
                                n_state = S_SETW;
                            end
                        end
                        ppfb_pkg::OP_READ: begin
                            n_mask = w_pix_mask;
                            n_bit  = 1'b0;
                            n_state = w_inside ? S_PXW : S_PXO;
                        end
                        ppfb_pkg::OP_FILL: begin
                            n_fill  = i_in.value;
                            n_addr  = '0;
                            n_dirty = '1;
                            n_state = S_FILL;
                        end
                        ppfb_pkg::OP_REFRESH: begin
                            n_tries = '0;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_FILL: begin
                w_we   = 1'b1;
                n_addr = r_addr + AW'(1);
                if (r_addr == AW'(FRAME - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_SETW: begin
                w_we    = 1'b1;
                w_wdata = r_setv ? (w_rdata | r_mask) : (w_rdata & ~r_mask);
                n_dirty[r_page] = 1'b1;
                n_state = S_IDLE;
            end
            S_PXW: begin
                n_bit   = |(w_rdata & r_mask);
                n_state = S_PXO;
            end
            S_PXO: begin
                if (w_slot) begin
                    w_load        = 1'b1;
                    n_out.kind    = ppfb_pkg::KIND_PIXEL;
                    n_out.payload = 64'(r_bit);
                    n_out.last    = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_SCAN: begin
                n_ptr   = (r_ptr == PW'(PAGES - 1)) ? '0 : r_ptr + PW'(1);
                n_tries = r_tries + TW'(1);
                if (r_dirty[r_ptr]) begin
                    n_page      = r_ptr;
                    n_page_base = AW'(32'(r_ptr) * COLUMNS);
                    n_state     = S_CMD;
                end else if (r_tries == TW'(PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_CMD: begin
                if (w_slot) begin
                    w_load          = 1'b1;
                    n_out.kind      = ppfb_pkg::KIND_CMD;
                    n_out.payload   = {40'd0, ppfb_pkg::CMD_COL_HIGH, ppfb_pkg::CMD_COL_LOW,
                                       ppfb_pkg::CMD_PAGE_BASE + 8'(r_page)};
                    n_out.last      = 1'b0;
                    n_dirty[r_page] = 1'b0;
                    n_col           = '0;
                    n_state         = S_READ;
                end
            end
            S_READ: begin
                w_raddr     = w_col_addr;
                n_pend      = 1'b1;
                n_pend_lane = r_col[2:0];
                n_pend_zero = (32'(r_col) >= COLUMNS);
                n_col       = r_col + CCW'(1);
                if (r_col[2:0] == 3'd7) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_PUT;
            end
            S_PUT: begin
                if (w_slot) begin
                    w_load        = 1'b1;
                    n_out.kind    = ppfb_pkg::KIND_DATA;
                    n_out.payload = r_word;
                    n_out.last    = (r_col == CCW'(WPP * 8));
                    n_state       = (r_col == CCW'(WPP * 8)) ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_addr      <= '0;
            r_fill      <= '0;
            r_dirty     <= '0;
            r_ptr       <= '0;
            r_tries     <= '0;
            r_col       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_fill      <= n_fill;
            r_dirty     <= n_dirty;
            r_ptr       <= n_ptr;
            r_tries     <= n_tries;
            r_col       <= n_col;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_mask      <= n_mask;
        r_setv      <= n_setv;
        r_page      <= n_page;
        r_page_base <= n_page_base;
        r_bit       <= n_bit;
        r_pend_lane <= n_pend_lane;
        r_pend_zero <= n_pend_zero;
        r_word      <= n_word;
        r_out       <= n_out;
    end

endmodule

`default_nettype wire

[rtl/ppfb_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
